[rtl/rrle_pkg.sv]
package rrle_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int VALUE_BITS   = 8;
  localparam int POS_BITS     = 12;
  localparam int ROW_BITS     = 12;
  localparam int SIZE_BITS    = 13;
  localparam int CFG_IDX_BITS = 4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_WIDTH   = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TILE_HEIGHT = 4'd1;

  localparam logic [SIZE_BITS-1:0] RESET_SIZE = 13'd256;

  // Operation kinds handed from the front to the back.
  localparam logic [1:0] KIND_CLOSE_PREV = 2'd0;  // value changed inside a row
  localparam logic [1:0] KIND_CLOSE_ROW  = 2'd1;  // last column extends or starts the run
  localparam logic [1:0] KIND_SPLIT_ROW  = 2'd2;  // last column differs: two runs

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;
  localparam int QUEUE_CNT_BITS = 3;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  last_row;
    logic [ROW_BITS-1:0]   row;
    logic [POS_BITS-1:0]   first;
    logic [POS_BITS-1:0]   col;
    logic [VALUE_BITS-1:0] prev_value;
    logic [VALUE_BITS-1:0] value;
  } rrle_op_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]   run_row;
    logic [POS_BITS-1:0]   run_first_col;
    logic [POS_BITS-1:0]   run_last_col;
    logic [VALUE_BITS-1:0] run_value;
    logic                  row_done;
    logic                  tile_done;
    logic                  last_result;
  } rrle_res_t;

  function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                     input logic [SIZE_BITS-1:0] limit);
    logic [SIZE_BITS-1:0] r;
    if (v == '0) begin
      r = SIZE_BITS'(1);
    end else if (v > limit) begin
      r = limit;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/rrle_if.sv]
interface rrle_pixel_if import rrle_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface rrle_run_if import rrle_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ROW_BITS-1:0]   run_row;
  logic [POS_BITS-1:0]   run_first_col;
  logic [POS_BITS-1:0]   run_last_col;
  logic [VALUE_BITS-1:0] run_value;
  logic                  row_done;
  logic                  tile_done;
  logic                  last_result;

  modport source (output valid, output run_row, output run_first_col, output run_last_col,
                  output run_value, output row_done, output tile_done,
                  output last_result, input ready);
  modport sink (input valid, input run_row, input run_first_col, input run_last_col,
                input run_value, input row_done, input tile_done, input last_result,
                output ready);
endinterface

interface rrle_cfg_if import rrle_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [SIZE_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/rrle_front.sv]
module rrle_front import rrle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  rrle_pixel_if.sink         pixel,
  rrle_cfg_if.sink           cfg,
  input  logic               full,
  output logic               push,
  output rrle_op_t           push_op
);

  logic [SIZE_BITS-1:0]  row_width;
  logic [SIZE_BITS-1:0]  tile_height;
  logic [POS_BITS-1:0]   column_count;
  logic [ROW_BITS-1:0]   row_count;
  logic [POS_BITS-1:0]   run_start;
  logic [VALUE_BITS-1:0] current_value;

  logic accept;
  logic last_col;
  logic last_row;
  logic first_col;
  logic changed;

  // Pixels wait while a register write is offered, so a write never meets a pixel transfer.
  assign pixel.ready = !full && !cfg.valid;
  assign cfg.ready   = 1'b1;
  assign accept      = pixel.valid && pixel.ready;

  assign first_col = (column_count == '0);
  assign changed   = (pixel.pixel_value != current_value);
  assign last_col  = (({1'b0, column_count} + SIZE_BITS'(1)) >= row_width);
  assign last_row  = (({1'b0, row_count} + SIZE_BITS'(1)) >= tile_height);

  always_comb begin
    push_op.kind       = KIND_CLOSE_ROW;
    push_op.last_row   = last_row;
    push_op.row        = row_count;
    push_op.first      = first_col ? '0 : run_start;
    push_op.col        = column_count;
    push_op.prev_value = current_value;
    push_op.value      = pixel.pixel_value;
    push               = 1'b0;
    if (accept) begin
      if (first_col) begin
        push = last_col;
      end else if (last_col) begin
        push         = 1'b1;
        push_op.kind = changed ? KIND_SPLIT_ROW : KIND_CLOSE_ROW;
      end else if (changed) begin
        push         = 1'b1;
        push_op.kind = KIND_CLOSE_PREV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width     <= RESET_SIZE;
      tile_height   <= RESET_SIZE;
      column_count  <= '0;
      row_count     <= '0;
      run_start     <= '0;
      current_value <= '0;
    end else if (cfg.valid) begin
      // A write to a known register restarts the tile.
      case (cfg.index)
        CFG_ROW_WIDTH: begin
          row_width     <= clamp_size(cfg.data, SIZE_BITS'(MAX_WIDTH));
          column_count  <= '0;
          row_count     <= '0;
          run_start     <= '0;
          current_value <= '0;
        end
        CFG_TILE_HEIGHT: begin
          tile_height   <= clamp_size(cfg.data, SIZE_BITS'(MAX_HEIGHT));
          column_count  <= '0;
          row_count     <= '0;
          run_start     <= '0;
          current_value <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (first_col || last_col || changed) begin
        run_start     <= column_count;
        current_value <= pixel.pixel_value;
      end
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_BITS'(1);
      end else begin
        column_count <= column_count + POS_BITS'(1);
      end
    end
  end

endmodule

[rtl/rrle_queue.sv]
module rrle_queue import rrle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rrle_op_t push_op,
  input  logic     pop,
  output rrle_op_t pop_op,
  output logic     not_empty,
  output logic     full
);

  rrle_op_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic                      do_push;
  logic                      do_pop;

  assign full      = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_op    = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QUEUE_CNT_BITS'(1);
      end
    end
  end

endmodule

[rtl/rrle_back.sv]
module rrle_back import rrle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rrle_op_t   op,
  input  logic       op_valid,
  output logic       pop,
  rrle_run_if.source run
);

  logic      out_valid;
  logic      phase;
  logic      load;
  logic      first_half;
  rrle_res_t res;
  rrle_res_t res_next;

  logic [POS_BITS-1:0] col_before;

  assign col_before = op.col - POS_BITS'(1);
  assign load       = op_valid && (!out_valid || run.ready);
  // A split operation gives its closing run first and stays queued for its second run.
  assign first_half = (op.kind == KIND_SPLIT_ROW) && !phase;
  assign pop        = load && !first_half;

  always_comb begin
    res_next.run_row = op.row;
    case (op.kind)
      KIND_CLOSE_PREV: begin
        res_next.run_first_col = op.first;
        res_next.run_last_col  = col_before;
        res_next.run_value     = op.prev_value;
        res_next.row_done      = 1'b0;
        res_next.tile_done     = 1'b0;
        res_next.last_result   = 1'b1;
      end
      KIND_SPLIT_ROW: begin
        if (phase) begin
          res_next.run_first_col = op.col;
          res_next.run_last_col  = op.col;
          res_next.run_value     = op.value;
          res_next.row_done      = 1'b1;
          res_next.tile_done     = op.last_row;
          res_next.last_result   = 1'b1;
        end else begin
          res_next.run_first_col = op.first;
          res_next.run_last_col  = col_before;
          res_next.run_value     = op.prev_value;
          res_next.row_done      = 1'b0;
          res_next.tile_done     = 1'b0;
          res_next.last_result   = 1'b0;
        end
      end
      default: begin
        res_next.run_first_col = op.first;
        res_next.run_last_col  = op.col;
        res_next.run_value     = op.value;
        res_next.row_done      = 1'b1;
        res_next.tile_done     = op.last_row;
        res_next.last_result   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= first_half;
      end else if (run.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  assign run.valid         = out_valid;
  assign run.run_row       = res.run_row;
  assign run.run_first_col = res.run_first_col;
  assign run.run_last_col  = res.run_last_col;
  assign run.run_value     = res.run_value;
  assign run.row_done      = res.row_done;
  assign run.tile_done     = res.tile_done;
  assign run.last_result   = res.last_result;

endmodule

[rtl/raster_row_run_length_encoder.sv]
// Path: a pixel that closes a run pushes its operation into the four-entry operation queue,
// from which the operation is loaded into the output register that drives the run's valid.
// Throughput: one pixel per cycle while the queue is not full and no write is offered;
// a differing pixel in the last column yields two runs, which the queue absorbs.
// Reset (rst, synchronous): row width and tile height return to 256, the tile restarts at
// row 0, column 0, and the queue and output register are emptied.
module raster_row_run_length_encoder import rrle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rrle_pixel_if.sink pixel,
  rrle_run_if.source run,
  rrle_cfg_if.sink   cfg
);

  logic     push;
  rrle_op_t push_op;
  logic     pop;
  rrle_op_t pop_op;
  logic     not_empty;
  logic     full;

  rrle_front u_front (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pixel),
    .cfg     (cfg),
    .full    (full),
    .push    (push),
    .push_op (push_op)
  );

  rrle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .pop_op    (pop_op),
    .not_empty (not_empty),
    .full      (full)
  );

  rrle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (pop_op),
    .op_valid (not_empty),
    .pop      (pop),
    .run      (run)
  );

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("operation pushed into a full queue");

  a_row_done_is_last: assert property (@(posedge clk) disable iff (rst)
    run.valid && run.row_done |-> run.last_result)
    else $error("row end run is not the last result of its pixel");

  a_tile_done_ends_row: assert property (@(posedge clk) disable iff (rst)
    run.valid && run.tile_done |-> run.row_done)
    else $error("tile end run does not end its row");

  a_run_ordered: assert property (@(posedge clk) disable iff (rst)
    run.valid |-> run.run_first_col <= run.run_last_col)
    else $error("run first column beyond its last column");
`endif

endmodule
